// ----- hdl/scp_pkg.sv -----
// Shared types and codes for the synchronization counter pool.
`timescale 1ns / 1ps
`default_nettype none
package scp_pkg;

   // Operation codes of a request.
   localparam logic [1:0] OP_ACQUIRE = 2'd0;
   localparam logic [1:0] OP_ADD     = 2'd1;
   localparam logic [1:0] OP_DEC     = 2'd2;
   localparam logic [1:0] OP_FREE    = 2'd3;

   // Result kinds.
   localparam logic [3:0] KIND_ACQUIRED  = 4'd0;
   localparam logic [3:0] KIND_NONE_FREE = 4'd1;
   localparam logic [3:0] KIND_BAD_VALUE = 4'd2;
   localparam logic [3:0] KIND_BAD_ID    = 4'd3;
   localparam logic [3:0] KIND_RELEASED  = 4'd4;
   localparam logic [3:0] KIND_QUEUED    = 4'd5;
   localparam logic [3:0] KIND_VALUE     = 4'd6;
   localparam logic [3:0] KIND_UNDERFLOW = 4'd7;
   localparam logic [3:0] KIND_FREED     = 4'd8;
   localparam logic [3:0] KIND_WAIT_FULL = 4'd9;
   localparam logic [3:0] KIND_FREE_FULL = 4'd10;

   // Most negative count; a decrement leaves it unchanged.
   localparam logic [31:0] MIN_COUNT = 32'h8000_0000;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] counter_id;
      logic [31:0] initial_value;
      logic [31:0] job_handle;
   } req_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] result_id;
      logic [30:0] count_value;
      logic [31:0] released_job;
      logic        last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic accept;
      logic lookup;
      logic exec;
      logic drain_rd;
      logic drain_emit;
      logic final_emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic out_free;
      logic need_drain;
      logic drain_last;
   } status_type;

endpackage
`default_nettype wire

// ----- hdl/sync_counter_pool.sv -----
// A request is accepted, looked up in registered memory reads and executed; execution waits
// while the result is stalled, then registers it. A decrement to zero with waiting jobs then
// emits each job as released, then a final value result. No new request is taken until all
// results are issued. Reset: a clearing pass over every address loads the counter, wait-count
// and free-id memories; req_ready is low until it ends. Wait-list job storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sync_counter_pool #(
   parameter int POOL_SIZE  = 256,
   parameter int WAIT_DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire scp_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output scp_pkg::rsp_type      rsp_payload
);
   import scp_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   scp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage and result datapath.
   scp_datapath #(
      .POOL_SIZE  (POOL_SIZE),
      .WAIT_DEPTH (WAIT_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
`default_nettype wire

// ----- hdl/scp_ctrl.sv -----
// Controller state machine of the synchronization counter pool.
`timescale 1ns / 1ps
`default_nettype none
module scp_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire scp_pkg::status_type status,
   output scp_pkg::cmd_type        cmd
);
   import scp_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_EXEC,
      ST_DRAIN_RD,
      ST_DRAIN_OUT,
      ST_FINAL
   } state_type;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.out_free) begin
               cmd.exec = 1'b1;
               state_in = status.need_drain ? ST_DRAIN_RD : ST_IDLE;
            end
         end
         ST_DRAIN_RD: begin
            cmd.drain_rd = 1'b1;
            state_in     = ST_DRAIN_OUT;
         end
         ST_DRAIN_OUT: begin
            if (status.out_free) begin
               cmd.drain_emit = 1'b1;
               state_in       = status.drain_last ? ST_FINAL : ST_DRAIN_RD;
            end
         end
         ST_FINAL: begin
            if (status.out_free) begin
               cmd.final_emit = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- hdl/scp_datapath.sv -----
// Datapath of the counter pool: memories, free list pointers and result register.
`timescale 1ns / 1ps
`default_nettype none
module scp_datapath #(
   parameter int POOL_SIZE  = 256,
   parameter int WAIT_DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire scp_pkg::req_type   req_payload,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output scp_pkg::rsp_type        rsp_payload,
   input  wire scp_pkg::cmd_type   cmd,
   output scp_pkg::status_type     status
);
   import scp_pkg::*;

   localparam int ID_W      = $clog2(POOL_SIZE);
   localparam int FCW       = $clog2(POOL_SIZE + 1);
   localparam int WCW       = $clog2(WAIT_DEPTH + 1);
   localparam int WI        = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int JOB_DEPTH = POOL_SIZE * (2 ** WI);

   // Storage.
   logic [31:0]     cval_mem [POOL_SIZE];
   logic [WCW-1:0]  wcnt_mem [POOL_SIZE];
   logic [ID_W-1:0] free_mem [POOL_SIZE];
   logic [31:0]     job_mem  [JOB_DEPTH];

   req_type         req_ff;
   logic [31:0]     cval_rd_ff;
   logic [WCW-1:0]  wcnt_rd_ff;
   logic [ID_W-1:0] free_rd_ff;
   logic [31:0]     job_rd_ff;
   logic [ID_W-1:0] clr_addr_ff;
   logic [ID_W-1:0] head_ff, head_in;
   logic [ID_W-1:0] tail_ff, tail_in;
   logic [FCW-1:0]  fcnt_ff, fcnt_in;
   logic [WCW-1:0]  didx_ff;
   logic [WCW-1:0]  dlim_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_ff;

   logic [ID_W-1:0]         ida;
   logic                    in_range;
   logic                    bad_init;
   logic [31:0]             dec_v;
   logic                    need_drain;
   rsp_type                 ex_rsp;
   logic                    cval_we, wcnt_we, free_we, job_we;
   logic [ID_W-1:0]         cval_wa, wcnt_wa, free_wa;
   logic [31:0]             cval_wd;
   logic [WCW-1:0]          wcnt_wd;
   logic [ID_W-1:0]         free_wd;
   logic [ID_W+WI-1:0]      job_wa;
   logic                    emit;
   rsp_type                 rsp_in;

   assign ida      = req_ff.counter_id[ID_W-1:0];
   assign in_range = (req_ff.counter_id < 16'(POOL_SIZE));
   assign bad_init = (req_ff.initial_value == 32'd0) || req_ff.initial_value[31];
   assign dec_v    = (cval_rd_ff == MIN_COUNT) ? cval_rd_ff : (cval_rd_ff - 32'd1);
   assign need_drain = (req_ff.operation == OP_DEC) && in_range && (dec_v == 32'd0)
                       && (wcnt_rd_ff != '0);

   // Request capture and clearing-pass address.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= ID_W'(clr_addr_ff + 1'b1);
      end
   end

   // Decision for one request and the memory writes it causes.
   always_comb begin
      ex_rsp  = '0;
      ex_rsp.last = 1'b1;
      ex_rsp.result_id = req_ff.counter_id;
      cval_we = 1'b0;
      cval_wa = ida;
      cval_wd = dec_v;
      wcnt_we = 1'b0;
      wcnt_wa = ida;
      wcnt_wd = '0;
      free_we = 1'b0;
      free_wa = tail_ff;
      free_wd = ida;
      job_we  = 1'b0;
      job_wa  = {ida, wcnt_rd_ff[WI-1:0]};
      head_in = head_ff;
      tail_in = tail_ff;
      fcnt_in = fcnt_ff;
      if (cmd.clear) begin
         cval_we = 1'b1;
         cval_wa = clr_addr_ff;
         cval_wd = '0;
         wcnt_we = 1'b1;
         wcnt_wa = clr_addr_ff;
         free_we = 1'b1;
         free_wa = clr_addr_ff;
         free_wd = clr_addr_ff;
      end else if (req_ff.operation == OP_ACQUIRE) begin
         ex_rsp.result_id = '0;
         if (bad_init) begin
            ex_rsp.kind = KIND_BAD_VALUE;
         end else if (fcnt_ff == '0) begin
            ex_rsp.kind = KIND_NONE_FREE;
         end else begin
            ex_rsp.kind      = KIND_ACQUIRED;
            ex_rsp.result_id = 16'(free_rd_ff);
            cval_we = cmd.exec;
            cval_wa = free_rd_ff;
            cval_wd = req_ff.initial_value;
            head_in = (head_ff == ID_W'(POOL_SIZE - 1)) ? '0 : ID_W'(head_ff + 1'b1);
            fcnt_in = FCW'(fcnt_ff - 1'b1);
         end
      end else if (!in_range) begin
         ex_rsp.kind = KIND_BAD_ID;
      end else if (req_ff.operation == OP_ADD) begin
         if (cval_rd_ff == 32'd0) begin
            ex_rsp.kind         = KIND_RELEASED;
            ex_rsp.released_job = req_ff.job_handle;
         end else if (wcnt_rd_ff >= WCW'(WAIT_DEPTH)) begin
            ex_rsp.kind = KIND_WAIT_FULL;
         end else begin
            ex_rsp.kind = KIND_QUEUED;
            job_we  = cmd.exec;
            wcnt_we = cmd.exec;
            wcnt_wd = WCW'(wcnt_rd_ff + 1'b1);
         end
      end else if (req_ff.operation == OP_DEC) begin
         cval_we = cmd.exec;
         if (dec_v[31]) begin
            ex_rsp.kind = KIND_UNDERFLOW;
         end else begin
            ex_rsp.kind        = KIND_VALUE;
            ex_rsp.count_value = dec_v[30:0];
            if (dec_v == 32'd0) begin
               wcnt_we = cmd.exec;
            end
         end
      end else begin
         if (fcnt_ff >= FCW'(POOL_SIZE)) begin
            ex_rsp.kind = KIND_FREE_FULL;
         end else begin
            ex_rsp.kind = KIND_FREED;
            free_we = cmd.exec;
            tail_in = (tail_ff == ID_W'(POOL_SIZE - 1)) ? '0 : ID_W'(tail_ff + 1'b1);
            fcnt_in = FCW'(fcnt_ff + 1'b1);
         end
      end
   end

   // Memory reads and writes.
   always_ff @(posedge clock) begin
      if (cval_we) begin
         cval_mem[cval_wa] <= cval_wd;
      end
      if (cmd.lookup) begin
         cval_rd_ff <= cval_mem[ida];
      end
   end

   always_ff @(posedge clock) begin
      if (wcnt_we) begin
         wcnt_mem[wcnt_wa] <= wcnt_wd;
      end
      if (cmd.lookup) begin
         wcnt_rd_ff <= wcnt_mem[ida];
      end
   end

   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[free_wa] <= free_wd;
      end
      if (cmd.lookup) begin
         free_rd_ff <= free_mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (job_we) begin
         job_mem[job_wa] <= req_ff.job_handle;
      end
      if (cmd.drain_rd) begin
         job_rd_ff <= job_mem[{ida, didx_ff[WI-1:0]}];
      end
   end

   // Free list pointers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fcnt_ff <= FCW'(POOL_SIZE);
      end else if (cmd.exec) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fcnt_ff <= fcnt_in;
      end
   end

   // Wait list walk on a decrement to zero.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         didx_ff <= '0;
         dlim_ff <= wcnt_rd_ff;
      end else if (cmd.drain_emit) begin
         didx_ff <= WCW'(didx_ff + 1'b1);
      end
   end

   // Result register.
   assign emit = (cmd.exec && !need_drain) || cmd.drain_emit || cmd.final_emit;

   always_comb begin
      rsp_in = ex_rsp;
      if (cmd.drain_emit) begin
         rsp_in              = '0;
         rsp_in.kind         = KIND_RELEASED;
         rsp_in.result_id    = req_ff.counter_id;
         rsp_in.released_job = job_rd_ff;
      end else if (cmd.final_emit) begin
         rsp_in           = '0;
         rsp_in.kind      = KIND_VALUE;
         rsp_in.result_id = req_ff.counter_id;
         rsp_in.last      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Status to the controller.
   assign status.clear_done = (clr_addr_ff == ID_W'(POOL_SIZE - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign status.need_drain = need_drain;
   assign status.drain_last = (WCW'(didx_ff + 1'b1) == dlim_ff);

endmodule
`default_nettype wire

// ----- hdl/scp_checker.sv -----
// Port-level checks of the counter pool and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module scp_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire scp_pkg::req_type req_payload,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire scp_pkg::rsp_type rsp_payload
);
   import scp_pkg::*;

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // Only a released job can be followed by more results of the same request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind != KIND_RELEASED) |-> rsp_payload.last)
      else $error("non-release result without last");

   // A count is reported only with the value kind.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind != KIND_VALUE) |-> (rsp_payload.count_value == '0))
      else $error("count on wrong kind");

   // A job token is reported only when released.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind != KIND_RELEASED) |-> (rsp_payload.released_job == '0))
      else $error("job token on wrong kind");

endmodule

bind sync_counter_pool scp_checker u_scp_checker (.*);
`default_nettype wire

// ----- tb/sync_counter_pool_tb.sv -----
// Self-checking testbench for the synchronization counter pool.
`timescale 1ns / 1ps
module sync_counter_pool_tb;
   import scp_pkg::*;

   localparam int POOL  = 256;
   localparam int DEPTH = 16;

   // Expected-result store and behavioral copy of the counter pool.
   class pool_scoreboard;
      logic [31:0] counts[POOL];
      logic [31:0] jobs[POOL][DEPTH];
      int unsigned waiting[POOL];
      logic [7:0]  free_list[POOL];
      int unsigned head, tail, nfree;
      rsp_type     pending[$];
      int          errors;

      function new();
         for (int i = 0; i < POOL; i++) begin
            counts[i] = '0;
            waiting[i] = 0;
            free_list[i] = i[7:0];
         end
         head = 0;
         tail = 0;
         nfree = POOL;
         errors = 0;
      endfunction

      function void push(logic [3:0] kind, logic [15:0] id, logic [30:0] cnt,
                         logic [31:0] job);
         rsp_type r;
         r.kind = kind;
         r.result_id = id;
         r.count_value = cnt;
         r.released_job = job;
         r.last = 1'b0;
         pending = {pending, r};
      endfunction

      // Works out every result that one accepted request causes.
      function void note_request(req_type q);
         logic [31:0] v;
         logic [7:0]  got;
         if (q.operation == OP_ACQUIRE) begin
            if (q.initial_value == 0 || q.initial_value[31]) begin
               push(KIND_BAD_VALUE, 0, 0, 0);
            end else if (nfree == 0) begin
               push(KIND_NONE_FREE, 0, 0, 0);
            end else begin
               got = free_list[head];
               head = (head + 1) % POOL;
               nfree--;
               counts[got] = q.initial_value;
               push(KIND_ACQUIRED, {8'd0, got}, 0, 0);
            end
         end else if (q.counter_id >= POOL) begin
            push(KIND_BAD_ID, q.counter_id, 0, 0);
         end else if (q.operation == OP_ADD) begin
            if (counts[q.counter_id] == 0) begin
               push(KIND_RELEASED, q.counter_id, 0, q.job_handle);
            end else if (waiting[q.counter_id] >= DEPTH) begin
               push(KIND_WAIT_FULL, q.counter_id, 0, 0);
            end else begin
               jobs[q.counter_id][waiting[q.counter_id]] = q.job_handle;
               waiting[q.counter_id]++;
               push(KIND_QUEUED, q.counter_id, 0, 0);
            end
         end else if (q.operation == OP_DEC) begin
            v = counts[q.counter_id];
            if (v != MIN_COUNT) v = v - 1;
            counts[q.counter_id] = v;
            if (v[31]) begin
               push(KIND_UNDERFLOW, q.counter_id, 0, 0);
            end else begin
               if (v == 0) begin
                  for (int i = 0; i < waiting[q.counter_id]; i++)
                     push(KIND_RELEASED, q.counter_id, 0, jobs[q.counter_id][i]);
                  waiting[q.counter_id] = 0;
               end
               push(KIND_VALUE, q.counter_id, v[30:0], 0);
            end
         end else begin
            if (nfree >= POOL) begin
               push(KIND_FREE_FULL, q.counter_id, 0, 0);
            end else begin
               free_list[tail] = q.counter_id[7:0];
               tail = (tail + 1) % POOL;
               nfree++;
               push(KIND_FREED, q.counter_id, 0, 0);
            end
         end
         pending[$].last = 1'b1;
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      // Compares one accepted result with the oldest expectation.
      task check_result(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result %p", got));
            return;
         end
         e = pending.pop_front();
         if (got.kind !== e.kind)
            report($sformatf("kind %0d, want %0d", got.kind, e.kind));
         if (got.result_id !== e.result_id)
            report($sformatf("id %0d, want %0d", got.result_id, e.result_id));
         if (got.count_value !== e.count_value)
            report($sformatf("count %0d, want %0d", got.count_value, e.count_value));
         if (got.released_job !== e.released_job)
            report($sformatf("job %h, want %h", got.released_job, e.released_job));
         if (got.last !== e.last)
            report($sformatf("last %b, want %b", got.last, e.last));
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   pool_scoreboard board = new();
   bit      calm = 1'b0;
   logic [7:0] held_ids[$];

   always #4 clock = ~clock;

   sync_counter_pool #(.POOL_SIZE(POOL), .WAIT_DEPTH(DEPTH)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   // Result side: sample at the rising edge, change ready at the falling edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_payload);
   end
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 10);
   end

   // Sends one request, idling now and then before it. Valid stays high after
   // acceptance until the next request or an idle stretch replaces it.
   task automatic send(logic [1:0] op, logic [15:0] id, logic [31:0] init,
                       logic [31:0] job);
      req_type q;
      q.operation = op;
      q.counter_id = id;
      q.initial_value = init;
      q.job_handle = job;
      if (!calm && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < 10);
      end
      req_valid <= 1'b1;
      req_payload <= q;
      do @(posedge clock); while (!req_ready);
      board.note_request(q);
      if (op == OP_ACQUIRE && board.pending[$].kind == KIND_ACQUIRED)
         held_ids = {held_ids, board.pending[$].result_id[7:0]};
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_id();
      int r;
      r = $urandom_range(99);
      if (r < 5) return 16'($urandom_range(65535, POOL));
      if (r < 85 && held_ids.size() != 0)
         return {8'd0, held_ids[$urandom_range(held_ids.size() - 1)]};
      return 16'($urandom_range(POOL - 1));
   endfunction

   // Run-time limit.
   initial begin
      #5ms;
      $display("sync_counter_pool_tb: errors");
      $finish;
   end

   initial begin
      int r;
      logic [15:0] id;
      logic [31:0] init;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part.
      send(OP_FREE, 16'd5, 0, 0);                  // free list already full
      send(OP_ACQUIRE, 0, 32'd0, 0);               // zero start
      send(OP_ACQUIRE, 0, 32'h8000_0000, 0);       // negative start
      send(OP_ACQUIRE, 0, 32'hFFFF_FFFF, 0);
      send(OP_ACQUIRE, 0, 32'd1, 0);               // id 0
      send(OP_ACQUIRE, 0, 32'h7FFF_FFFF, 0);       // id 1
      send(OP_ADD, 16'd2, 0, 32'hFFFF_FFFF);       // zero counter releases at once
      send(OP_ADD, 16'hFFFF, 0, 0);                // out of range
      send(OP_DEC, 16'd256, 0, 0);
      send(OP_FREE, 16'd256, 0, 0);
      for (int i = 0; i < DEPTH; i++) send(OP_ADD, 16'd0, 0, 32'hA500_0000 + i);
      send(OP_ADD, 16'd0, 0, 32'h1234_5678);       // wait list full
      send(OP_DEC, 16'd0, 0, 0);                   // reaches zero with all waiters
      send(OP_DEC, 16'd0, 0, 0);                   // goes negative
      send(OP_DEC, 16'd1, 0, 0);
      send(OP_DEC, 16'd3, 0, 0);                   // never acquired, goes negative
      drain();

      // Random part: mostly well-formed acquire, wait and count-down use.
      for (int n = 0; n < 180; n++) begin
         if (n == 110) drain();                    // sender holds off until idle
         if (n == 60) calm = 1'b1;
         if (n == 100) calm = 1'b0;
         r = $urandom_range(99);
         id = pick_id();
         if (r < 20) begin
            r = $urandom_range(9);
            init = (r == 0) ? $urandom() : (r == 1) ? 32'h7FFF_FFFF
                 : 32'($urandom_range(4, 1));
            send(OP_ACQUIRE, 0, init, 0);
         end else if (r < 55) begin
            send(OP_ADD, id, 0, $urandom());
         end else if (r < 90) begin
            send(OP_DEC, id, 0, 0);
         end else begin
            send(OP_FREE, id, 0, 0);
         end
      end

      drain();
      repeat (50) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("sync_counter_pool_tb: clean");
      end else begin
         $display("sync_counter_pool_tb: errors");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
hdl/scp_pkg.sv
hdl/scp_ctrl.sv
hdl/scp_datapath.sv
hdl/sync_counter_pool.sv
hdl/scp_checker.sv
tb/sync_counter_pool_tb.sv
